### hdl/assert_macros.svh
// Assertion macros shared by the RTL. They compile to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Checks that a condition holds on every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
    else $error("invariant violated");

`else

`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_ALWAYS(lbl, clk, rstn, cond)

`endif

`endif

### hdl/bsrs_pkg.sv
package bsrs_pkg;

  localparam int unsigned ActW  = 3;
  localparam int unsigned ValW  = 32;
  localparam int unsigned LimW  = 5;
  localparam int unsigned EcW   = 5;
  localparam int unsigned ErrW  = 2;

  localparam int unsigned DepthDefault = 16;
  localparam logic [LimW-1:0] LimitReset = 5'd10;

  localparam int unsigned InTdataW  = ((ActW + ValW + 7) / 8) * 8;
  localparam int unsigned OutBits   = ValW + 1 + EcW + 1 + ErrW;
  localparam int unsigned OutTdataW = ((OutBits + 7) / 8) * 8;

  localparam logic [ActW-1:0] ActPush  = 3'd0;
  localparam logic [ActW-1:0] ActPop   = 3'd1;
  localparam logic [ActW-1:0] ActSwap  = 3'd2;
  localparam logic [ActW-1:0] ActRev   = 3'd3;
  localparam logic [ActW-1:0] ActExist = 3'd4;
  localparam logic [ActW-1:0] ActClear = 3'd5;

  localparam logic [ErrW-1:0] ErrNone  = 2'd0;
  localparam logic [ErrW-1:0] ErrFull  = 2'd1;
  localparam logic [ErrW-1:0] ErrEmpty = 2'd2;

endpackage

### hdl/bounded_stack_with_swap_reverse_search_core.sv
// Bounded LIFO stack of signed 32-bit values held in a single-port-read RAM.
// Requests arrive on the s_axis channel: tdata carries the action code and an
// operand (push, pop, swap top with bottom, reverse, search, clear). Each
// request produces exactly one response on m_axis with the new top entry,
// its valid flag, the entry count, the search hit flag and an error code.
// The capacity comes from cfg_wdata_i, written when cfg_we_i is high, and is
// clipped to DEPTH.
// Each request steps through states in order: push, pop, clear and unused
// codes go straight to StTop and StOut; swap reads both ends (StRdI, StRdJ),
// writes them back (StWrI, StWrJ), then goes to StTop and StOut; reverse
// repeats the four swap states per pair; search repeats StSrch and StCmp per
// entry examined, stopping at the first hit. Every entry read goes through the single RAM read port.
// tready is high only while the sequencer is idle, which includes the cycle
// after the response register is loaded, so a new request may enter while a
// response waits. No new request is taken until the previous response is loaded.
// When m_axis stalls, a finished result holds in its state until the output
// register frees. Reset empties the stack and sets the capacity to 10; the
// RAM contents are not cleared.
`include "assert_macros.svh"

module bounded_stack_with_swap_reverse_search_core import bsrs_pkg::*; #(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [LimW-1:0]      cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [2:0] action, [34:3] value, rest zero
  input  logic [InTdataW-1:0]  s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [31:0] top_value, [32] top_valid, [37:33] entry_count, [38] found,
  // [40:39] error, rest zero
  output logic [OutTdataW-1:0] m_axis_tdata
);

  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CapW = (CW > LimW) ? CW : LimW;

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StRdI  = 4'd1;
  localparam logic [3:0] StRdJ  = 4'd2;
  localparam logic [3:0] StWrI  = 4'd3;
  localparam logic [3:0] StWrJ  = 4'd4;
  localparam logic [3:0] StSrch = 4'd5;
  localparam logic [3:0] StCmp  = 4'd6;
  localparam logic [3:0] StTop  = 4'd7;
  localparam logic [3:0] StOut  = 4'd8;

  logic [3:0]           state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [LimW-1:0]      limit_q;
  logic [AW-1:0]        i_q, i_d, j_q, j_d;
  logic                 single_q, single_d;
  logic [ValW-1:0]      val_q, val_d;
  logic [ValW-1:0]      tmp_q, tmp_d;
  logic                 found_q, found_d;
  logic [ErrW-1:0]      err_q, err_d;
  logic                 out_valid_q, out_valid_d;
  logic [OutTdataW-1:0] out_data_q, out_data_d;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [ValW-1:0]      ram_wdata, ram_rdata;

  logic                 in_accept;
  logic [ActW-1:0]      in_action;
  logic [ValW-1:0]      in_value;
  logic [CW-1:0]        cnt_m1;
  logic [CapW-1:0]      cap;
  logic                 full;
  logic [AW-1:0]        pair_gap;
  logic [ValW-1:0]      top_value;
  logic                 push_take;
  logic                 push_refused;
  logic                 out_cnt_nz;

  assign in_action = s_axis_tdata[ActW-1:0];
  assign in_value  = s_axis_tdata[ActW+ValW-1:ActW];
  assign s_axis_tready = (state_q == StIdle);
  assign in_accept = s_axis_tvalid && s_axis_tready;

  assign cnt_m1   = cnt_q - CW'(1);
  assign cap      = (CapW'(limit_q) > CapW'(DEPTH)) ? CapW'(DEPTH) : CapW'(limit_q);
  assign full     = (CapW'(cnt_q) >= cap);
  assign pair_gap = j_q - i_q;
  assign top_value = (cnt_q != '0) ? ram_rdata : '0;

  bsrs_ram #(
    .Width(ValW),
    .Depth(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    i_d         = i_q;
    j_d         = j_q;
    single_d    = single_q;
    val_d       = val_q;
    tmp_d       = tmp_q;
    found_d     = found_q;
    err_d       = err_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_waddr   = i_q;
    ram_wdata   = ram_rdata;
    // Parking the read port on the top slot keeps the top entry available
    // while a finished response waits for the output register.
    ram_raddr   = cnt_m1[AW-1:0];

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_accept) begin
          found_d = 1'b0;
          err_d   = ErrNone;
          val_d   = in_value;
          state_d = StTop;
          case (in_action)
            ActPush: begin
              if (full) begin
                err_d = ErrFull;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = cnt_q[AW-1:0];
                ram_wdata = in_value;
                cnt_d     = cnt_q + CW'(1);
              end
            end
            ActPop: begin
              if (cnt_q == '0) begin
                err_d = ErrEmpty;
              end else begin
                cnt_d = cnt_m1;
              end
            end
            ActSwap, ActRev: begin
              if ((in_action == ActSwap) && (cnt_q == '0)) begin
                err_d = ErrEmpty;
              end else if (cnt_q > CW'(1)) begin
                i_d      = '0;
                j_d      = cnt_m1[AW-1:0];
                single_d = (in_action == ActSwap);
                state_d  = StRdI;
              end
            end
            ActExist: begin
              if (cnt_q != '0) begin
                i_d     = '0;
                state_d = StSrch;
              end
            end
            ActClear: begin
              cnt_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      StRdI: begin
        ram_raddr = i_q;
        state_d   = StRdJ;
      end
      StRdJ: begin
        ram_raddr = j_q;
        tmp_d     = ram_rdata;
        state_d   = StWrI;
      end
      StWrI: begin
        ram_we    = 1'b1;
        ram_waddr = i_q;
        ram_wdata = ram_rdata;
        state_d   = StWrJ;
      end
      StWrJ: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = tmp_q;
        i_d       = i_q + AW'(1);
        j_d       = j_q - AW'(1);
        // Another pair remains only while the pointers are more than two apart.
        if (!single_q && ({1'b0, pair_gap} > (AW + 1)'(2))) begin
          state_d = StRdI;
        end else begin
          state_d = StTop;
        end
      end
      StSrch: begin
        ram_raddr = i_q;
        state_d   = StCmp;
      end
      StCmp: begin
        if (ram_rdata == val_q) begin
          found_d = 1'b1;
          state_d = StTop;
        end else if ((CW'(i_q) + CW'(1)) < cnt_q) begin
          i_d     = i_q + AW'(1);
          state_d = StSrch;
        end else begin
          state_d = StTop;
        end
      end
      StTop: begin
        state_d = StOut;
      end
      StOut: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = OutTdataW'({err_q, found_q, EcW'(cnt_q), (cnt_q != '0), top_value});
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      limit_q     <= LimitReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q        <= i_d;
    j_q        <= j_d;
    single_q   <= single_d;
    val_q      <= val_d;
    tmp_q      <= tmp_d;
    found_q    <= found_d;
    err_q      <= err_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign push_take    = in_accept && (in_action == ActPush) && !full;
  assign push_refused = in_accept && (in_action == ActPush) && full;
  assign out_cnt_nz   = (m_axis_tdata[ValW+EcW:ValW+1] != '0);

  `ASSERT_ALWAYS(a_cnt_bounded, clk_i, rst_ni, cnt_q <= CW'(DEPTH))
  `ASSERT_PROP(a_push_grows, clk_i, rst_ni, push_take |=> (cnt_q == $past(cnt_q) + CW'(1)))
  `ASSERT_PROP(a_top_valid_match, clk_i, rst_ni, m_axis_tvalid |-> m_axis_tdata[ValW] == out_cnt_nz)
  `ASSERT_PROP(a_full_refused, clk_i, rst_ni, push_refused |=> $stable(cnt_q))

endmodule

### hdl/bsrs_ram.sv
module bsrs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
